>>> src/dxt_block_decoder_core_defines.svh
// Shared assertion macros for the block decoder.
`ifndef DXT_BLOCK_DECODER_CORE_DEFINES_SVH
`define DXT_BLOCK_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DXTD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dxtd assertion failed");

// Next-cycle implication, checked out of reset.
`define DXTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dxtd assertion failed");

`endif

>>> src/dxtd_pkg.sv
package dxtd_pkg;

  // block_format register codes; the unused code decodes as DXT5
  localparam logic [1:0] FMT_DXT1  = 2'd0;
  localparam logic [1:0] FMT_DXT3  = 2'd1;
  localparam logic [1:0] FMT_DXT5  = 2'd2;
  localparam logic [1:0] FMT_RESET = FMT_DXT5;

  // alpha source of a classified block
  localparam logic [1:0] AM_PALETTE  = 2'd0;
  localparam logic [1:0] AM_EXPLICIT = 2'd1;
  localparam logic [1:0] AM_INTERP   = 2'd2;

  localparam int unsigned PIXELS = 16;

  // classified block: palette and alpha levels ready, indices still packed
  typedef struct packed {
    logic [3:0][2:0][7:0] pal;        // entry, channel (0 red, 1 green, 2 blue)
    logic                 three_mode; // DXT1 three colors plus transparent black
    logic [31:0]          cidx;       // 2-bit color index per pixel
    logic [1:0]           amode;
    logic [7:0][7:0]      alv;        // DXT5 alpha levels
    logic [63:0]          abits;      // alpha half of the block
  } blk_t;

endpackage

>>> src/dxtd_front.sv
module dxtd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         fmt,
  input  logic [63:0]        first_half,
  input  logic [63:0]        second_half,
  input  logic               q_full,
  output logic               push,
  output dxtd_pkg::blk_t     push_data
);

  typedef struct packed {
    logic [2:0][7:0]  e0;
    logic [2:0][7:0]  e1;
    logic [2:0][9:0]  sum21;   // 2*e0 + e1
    logic [2:0][9:0]  sum12;   // e0 + 2*e1
    logic             three_mode;
    logic [31:0]      cidx;
    logic [1:0]       amode;
    logic [7:0]       a0;
    logic [7:0]       a1;
    logic             six_mode;
    logic [5:0][10:0] asum;    // weighted alpha sums before the divide
    logic [63:0]      abits;
  } s1_t;

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] p;
    p = 20'(x) * 20'd683;
    return p[18:11];
  endfunction

  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd3277;
    return p[21:14];
  endfunction

  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'd2341;
    return p[21:14];
  endfunction

  logic        s1_valid_r, s1_valid_nxt;
  s1_t         s1_r, s1_nxt;
  logic        accept;
  logic [63:0] cword;
  logic [15:0] c0, c1;
  logic [2:0]  w0, w1;
  logic [8:0]  avg;

  assign busy   = s1_valid_r & q_full;
  assign accept = start & ~busy;
  assign push   = s1_valid_r & ~q_full;

  // classify and form the sums at accept
  always_comb begin
    cword = (fmt == dxtd_pkg::FMT_DXT1) ? first_half : second_half;
    c0    = cword[15:0];
    c1    = cword[31:16];
    s1_nxt.e0[0] = {c0[15:11], 3'b000};
    s1_nxt.e0[1] = {c0[10:5], 2'b00};
    s1_nxt.e0[2] = {c0[4:0], 3'b000};
    s1_nxt.e1[0] = {c1[15:11], 3'b000};
    s1_nxt.e1[1] = {c1[10:5], 2'b00};
    s1_nxt.e1[2] = {c1[4:0], 3'b000};
    for (int ch = 0; ch < 3; ch++) begin
      s1_nxt.sum21[ch] = {1'b0, s1_nxt.e0[ch], 1'b0} + 10'(s1_nxt.e1[ch]);
      s1_nxt.sum12[ch] = 10'(s1_nxt.e0[ch]) + {1'b0, s1_nxt.e1[ch], 1'b0};
    end
    s1_nxt.three_mode = (fmt == dxtd_pkg::FMT_DXT1) && (c0 <= c1);
    s1_nxt.cidx       = cword[63:32];
    if (fmt == dxtd_pkg::FMT_DXT1) begin
      s1_nxt.amode = dxtd_pkg::AM_PALETTE;
    end else if (fmt == dxtd_pkg::FMT_DXT3) begin
      s1_nxt.amode = dxtd_pkg::AM_EXPLICIT;
    end else begin
      s1_nxt.amode = dxtd_pkg::AM_INTERP;
    end
    s1_nxt.a0       = first_half[7:0];
    s1_nxt.a1       = first_half[15:8];
    s1_nxt.six_mode = first_half[7:0] <= first_half[15:8];
    w0 = '0;
    w1 = '0;
    for (int j = 0; j < 6; j++) begin
      w0 = s1_nxt.six_mode ? 3'(4 - j) : 3'(6 - j);
      w1 = 3'(j + 1);
      s1_nxt.asum[j] = 11'(w0) * 11'(s1_nxt.a0) + 11'(w1) * 11'(s1_nxt.a1);
    end
    s1_nxt.abits = first_half;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  // divide the sums and build palette and alpha levels
  always_comb begin
    avg = '0;
    for (int ch = 0; ch < 3; ch++) begin
      avg = 9'(s1_r.e0[ch]) + 9'(s1_r.e1[ch]);
      push_data.pal[0][ch] = s1_r.e0[ch];
      push_data.pal[1][ch] = s1_r.e1[ch];
      push_data.pal[2][ch] = s1_r.three_mode ? avg[8:1] : div3(s1_r.sum21[ch]);
      push_data.pal[3][ch] = s1_r.three_mode ? 8'd0 : div3(s1_r.sum12[ch]);
    end
    push_data.three_mode = s1_r.three_mode;
    push_data.cidx       = s1_r.cidx;
    push_data.amode      = s1_r.amode;
    push_data.abits      = s1_r.abits;
    push_data.alv[0]     = s1_r.a0;
    push_data.alv[1]     = s1_r.a1;
    for (int j = 0; j < 6; j++) begin
      if (s1_r.six_mode && (j == 4)) begin
        push_data.alv[j + 2] = 8'd0;
      end else if (s1_r.six_mode && (j == 5)) begin
        push_data.alv[j + 2] = 8'hff;
      end else if (s1_r.six_mode) begin
        push_data.alv[j + 2] = div5(s1_r.asum[j]);
      end else begin
        push_data.alv[j + 2] = div7(s1_r.asum[j]);
      end
    end
  end

endmodule

>>> src/dxtd_queue.sv
`include "dxt_block_decoder_core_defines.svh"

module dxtd_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dxtd_pkg::blk_t push_data,
  input  logic           pop,
  output dxtd_pkg::blk_t pop_data,
  output logic           full,
  output logic           empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dxtd_pkg::blk_t entries_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  `DXTD_ASSERT_IMP(a_no_overflow, clk, rst_n, full, !push)
  `DXTD_ASSERT_IMP(a_no_underflow, clk, rst_n, empty, !pop)

endmodule

>>> src/dxtd_back.sv
`include "dxt_block_decoder_core_defines.svh"

module dxtd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  dxtd_pkg::blk_t q_data,
  output logic           pop,
  output logic           out_valid,
  output logic [7:0]     out_red,
  output logic [7:0]     out_green,
  output logic [7:0]     out_blue,
  output logic [7:0]     out_alpha,
  output logic [3:0]     out_pixel_number,
  output logic           out_last_pixel
);

  dxtd_pkg::blk_t cur_r;
  logic           cur_valid_r, cur_valid_nxt;
  logic [3:0]     cnt_r, cnt_nxt;
  logic           out_valid_r;
  logic [7:0]     red_r, green_r, blue_r, alpha_r;
  logic [3:0]     pix_r;
  logic           last_r;
  logic [1:0]     ci;
  logic [3:0]     nib;
  logic [5:0]     apos;
  logic [2:0]     ai;
  logic [7:0]     alpha_nxt;
  logic           at_end;

  assign at_end = (cnt_r == 4'(dxtd_pkg::PIXELS - 1));
  assign pop    = ~q_empty & (~cur_valid_r | at_end);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cnt_nxt       = cnt_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      cnt_nxt       = '0;
    end else if (cur_valid_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (at_end) begin
        cur_valid_nxt = 1'b0;
      end
    end
  end

  // select the pixel at the counter
  always_comb begin
    ci   = cur_r.cidx[{cnt_r, 1'b0} +: 2];
    nib  = cur_r.abits[{cnt_r, 2'b00} +: 4];
    apos = 6'd16 + 6'({cnt_r, 1'b0}) + 6'(cnt_r);
    ai   = cur_r.abits[apos +: 3];
    unique case (cur_r.amode)
      dxtd_pkg::AM_PALETTE: begin
        alpha_nxt = (cur_r.three_mode && (ci == 2'd3)) ? 8'd0 : 8'hff;
      end
      dxtd_pkg::AM_EXPLICIT: begin
        alpha_nxt = {nib, nib};
      end
      default: begin
        alpha_nxt = cur_r.alv[ai];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= cur_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_data;
    end
    red_r   <= cur_r.pal[ci][0];
    green_r <= cur_r.pal[ci][1];
    blue_r  <= cur_r.pal[ci][2];
    alpha_r <= alpha_nxt;
    pix_r   <= cnt_r;
    last_r  <= at_end;
  end

  assign out_valid        = out_valid_r;
  assign out_red          = red_r;
  assign out_green        = green_r;
  assign out_blue         = blue_r;
  assign out_alpha        = alpha_r;
  assign out_pixel_number = pix_r;
  assign out_last_pixel   = last_r;

  // a block goes out as sixteen strobes with no gap
  `DXTD_ASSERT_NEXT(a_pixels_contiguous, clk, rst_n, out_valid_r && !last_r, out_valid_r && (pix_r == $past(pix_r) + 4'd1))

endmodule

>>> src/dxt_block_decoder_core.sv
// Channel       | Ports                                        | Handshake
// --------------+----------------------------------------------+--------------------------
// block in      | in_first_half, in_second_half                | start high, busy low
// pixel out     | out_red/green/blue/alpha, out_pixel_number,  | out_valid strobe, 1 cycle
//               | out_last_pixel                               |
// configuration | cfg_wdata (block_format)                     | cfg_we, always taken
//
// The pixel stage emits one pixel per cycle, sixteen per block, while the front
// classifies further blocks into the queue. After a block is accepted its first
// pixel passes the classify register, queue write, pixel-stage load and output register.
// Reset (rst_n low at a clock edge) empties every stage and sets block_format to DXT5.
// busy rises only when the classify register is full and the queue has no room.
// The receiver cannot stall; out_valid marks each transaction for one cycle.
module dxt_block_decoder_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_first_half,
  input  logic [63:0] in_second_half,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [3:0]  out_pixel_number,
  output logic        out_last_pixel
);

  // block_format register
  logic [1:0]     fmt_r;

  // front to queue
  logic           push;
  dxtd_pkg::blk_t push_data;
  logic           q_full;

  // queue to back
  logic           pop;
  dxtd_pkg::blk_t pop_data;
  logic           q_empty;

  // Hold the format; write it only while the block is idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= dxtd_pkg::FMT_RESET;
    end else if (cfg_we) begin
      fmt_r <= cfg_wdata;
    end
  end

  // Front: accept a block, expand endpoints and form palette and alpha levels.
  dxtd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .fmt         (fmt_r),
    .first_half  (in_first_half),
    .second_half (in_second_half),
    .q_full      (q_full),
    .push        (push),
    .push_data   (push_data)
  );

  // Queue: decouple classification from pixel emission.
  dxtd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: advance through the sixteen pixels, one transaction per cycle.
  dxtd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_data           (pop_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_pixel_number (out_pixel_number),
    .out_last_pixel   (out_last_pixel)
  );

endmodule
